/* src/gpio_chord_key_mapper_top_macros.svh */
// assertion helpers used by gckm_back
`ifndef GPIO_CHORD_KEY_MAPPER_TOP_MACROS_SVH
`define GPIO_CHORD_KEY_MAPPER_TOP_MACROS_SVH

// same-cycle implication
`define GCKM_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("gckm assertion failed");

// next-cycle implication
`define GCKM_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("gckm assertion failed");

`endif

/* src/gckm_pkg.sv */
`timescale 1ns / 1ps

package gckm_pkg;

    localparam int NUM_GPIOS_DEF    = 16;
    localparam int NUM_MAPPINGS_DEF = 4;
    localparam int QUEUE_DEPTH      = 2;

    localparam logic [1:0] CMD_EXPANDER  = 2'd0;
    localparam logic [1:0] CMD_POWER     = 2'd1;
    localparam logic [1:0] CMD_MAP_WRITE = 2'd2;

    localparam logic [2:0] REG_PIN_MAP    = 3'd0;
    localparam logic [2:0] REG_POLARITY   = 3'd1;
    localparam logic [2:0] REG_GPIO_COUNT = 3'd2;
    localparam logic [2:0] REG_SHORT_KEY  = 3'd3;
    localparam logic [2:0] REG_LONG_KEY   = 3'd4;

    localparam logic [63:0] PIN_MAP_RST    = 64'hFEDC_BA98_7654_3210;
    localparam logic [15:0] POLARITY_RST   = 16'd0;
    localparam logic [4:0]  GPIO_COUNT_RST = 5'd16;
    localparam logic [9:0]  SHORT_KEY_RST  = 10'd16;
    localparam logic [9:0]  LONG_KEY_RST   = 10'd28;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] irq_mask;
        logic [15:0] level_mask;
        logic        short_press;
        logic        long_press;
        logic [1:0]  entry_index;
        logic [15:0] entry_gpios;
        logic [9:0]  entry_key;
        logic        entry_kind;
    } in_t;

    typedef struct packed {
        logic [9:0] key_code;
        logic       pressed;
        logic       kind;
        logic [1:0] slot;
        logic       last;
    } out_t;

    typedef struct packed {
        logic [63:0] pin_map;
        logic [15:0] polarity_mask;
        logic [4:0]  gpio_count;
        logic [9:0]  short_press_key;
        logic [9:0]  long_press_key;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] now;
        logic [15:0] prev;
        logic [15:0] hit;
        logic [15:0] used;
        logic        short_press;
        logic        long_press;
        logic [1:0]  entry_index;
        logic [15:0] entry_gpios;
        logic [9:0]  entry_key;
        logic        entry_kind;
    } job_t;

endpackage

/* src/gpio_chord_key_mapper_top.sv */
`timescale 1ns / 1ps

// Chord key mapper. A command is taken when start is high and busy is low; a two-entry
// queue sits between the command front end and the event engine, so busy rises only when
// both entries wait. An expander event walks every gpio against every mapping slot, one
// slot per cycle. Results come out one per cycle at most, each valid on strobe for a
// single cycle, and the receiver cannot stall them; a result is held back until the
// next one of the same command is found or the command finishes, and shows on strobe
// the cycle after that, so the final one of a command can carry last. Registers sit on
// the APB port at byte address 8*i, 64-bit data.

module gpio_chord_key_mapper_top
    import gckm_pkg::*;
#(
    parameter int NUM_GPIOS    = NUM_GPIOS_DEF,
    parameter int NUM_MAPPINGS = NUM_MAPPINGS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  in_t         item,
    output logic        strobe,
    output out_t        result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic accept;
    logic push;
    logic pop;
    logic empty;
    logic full;
    job_t wr_job;
    job_t rd_job;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign busy   = full;
    assign accept = start && !busy;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[5:3])
                REG_PIN_MAP:    cfg_next.pin_map         = pwdata;
                REG_POLARITY:   cfg_next.polarity_mask   = pwdata[15:0];
                REG_GPIO_COUNT: cfg_next.gpio_count      = pwdata[4:0];
                REG_SHORT_KEY:  cfg_next.short_press_key = pwdata[9:0];
                REG_LONG_KEY:   cfg_next.long_press_key  = pwdata[9:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_PIN_MAP:    prdata = cfg_reg.pin_map;
            REG_POLARITY:   prdata = 64'(cfg_reg.polarity_mask);
            REG_GPIO_COUNT: prdata = 64'(cfg_reg.gpio_count);
            REG_SHORT_KEY:  prdata = 64'(cfg_reg.short_press_key);
            REG_LONG_KEY:   prdata = 64'(cfg_reg.long_press_key);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pin_map         <= PIN_MAP_RST;
            cfg_reg.polarity_mask   <= POLARITY_RST;
            cfg_reg.gpio_count      <= GPIO_COUNT_RST;
            cfg_reg.short_press_key <= SHORT_KEY_RST;
            cfg_reg.long_press_key  <= LONG_KEY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    gckm_front #(
        .NUM_GPIOS (NUM_GPIOS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cfg    (cfg_reg),
        .push   (push),
        .job    (wr_job)
    );

    gckm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .empty  (empty),
        .full   (full)
    );

    gckm_back #(
        .NUM_GPIOS    (NUM_GPIOS),
        .NUM_MAPPINGS (NUM_MAPPINGS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .empty  (empty),
        .rd_job (rd_job),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

/* src/gckm_front.sv */
`timescale 1ns / 1ps

module gckm_front
    import gckm_pkg::*;
#(
    parameter int NUM_GPIOS = NUM_GPIOS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic accept,
    input  in_t  item,
    input  cfg_t cfg,
    output logic push,
    output job_t job
);

    logic [NUM_GPIOS-1:0] levels_reg;
    logic [NUM_GPIOS-1:0] levels_next;
    logic [NUM_GPIOS-1:0] now;
    logic [NUM_GPIOS-1:0] irq_hit;
    logic [NUM_GPIOS-1:0] used;
    logic [4:0]           cnt;

    always_comb
    begin
        cnt = (cfg.gpio_count > 5'(NUM_GPIOS)) ? 5'(NUM_GPIOS) : cfg.gpio_count;
        for (int g = 0; g < NUM_GPIOS; g++)
        begin
            used[g]    = (5'(g) < cnt);
            now[g]     = used[g] & item.level_mask[cfg.pin_map[4*g +: 4]];
            irq_hit[g] = item.irq_mask[cfg.pin_map[4*g +: 4]];
        end
    end

    always_comb
    begin
        job.command     = item.command;
        job.now         = 16'(now);
        job.prev        = 16'(levels_reg);
        job.hit         = 16'((irq_hit | (now ^ levels_reg)) & used);
        job.used        = 16'(used);
        job.short_press = item.short_press;
        job.long_press  = item.long_press;
        job.entry_index = item.entry_index;
        job.entry_gpios = item.entry_gpios;
        job.entry_key   = item.entry_key;
        job.entry_kind  = item.entry_kind;
        push = accept && (item.command inside {CMD_EXPANDER, CMD_POWER, CMD_MAP_WRITE});
        levels_next = (accept && item.command == CMD_EXPANDER) ? now : levels_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= '0;
        end
        else
        begin
            levels_reg <= levels_next;
        end
    end

endmodule

/* src/gckm_fifo.sv */
`timescale 1ns / 1ps

module gckm_fifo
    import gckm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wr_job,
    input  logic pop,
    output job_t rd_job,
    output logic empty,
    output logic full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t          entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign empty  = (count_reg == '0);
    assign full   = (count_reg == CW'(DEPTH));
    assign rd_job = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/gckm_back.sv */
`timescale 1ns / 1ps
`include "gpio_chord_key_mapper_top_macros.svh"

module gckm_back
    import gckm_pkg::*;
#(
    parameter int NUM_GPIOS    = NUM_GPIOS_DEF,
    parameter int NUM_MAPPINGS = NUM_MAPPINGS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic empty,
    input  job_t rd_job,
    output logic pop,
    output logic strobe,
    output out_t result
);

    localparam int GW = (NUM_GPIOS > 1) ? $clog2(NUM_GPIOS) : 1;
    localparam int SW = (NUM_MAPPINGS > 1) ? $clog2(NUM_MAPPINGS) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_POWER = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    job_t                 job_reg;
    job_t                 job_next;
    logic [GW-1:0]        g_reg;
    logic [GW-1:0]        g_next;
    logic [SW-1:0]        s_reg;
    logic [SW-1:0]        s_next;
    logic                 found_reg;
    logic                 found_next;
    logic [1:0]           pstep_reg;
    logic [1:0]           pstep_next;

    logic [NUM_GPIOS-1:0] members_reg [NUM_MAPPINGS];
    logic [NUM_GPIOS-1:0] members_next [NUM_MAPPINGS];
    logic [9:0]           code_reg [NUM_MAPPINGS];
    logic [9:0]           code_next [NUM_MAPPINGS];
    logic                 mtype_reg [NUM_MAPPINGS];
    logic                 mtype_next [NUM_MAPPINGS];
    logic                 active_reg [NUM_MAPPINGS];
    logic                 active_next [NUM_MAPPINGS];

    logic                 pend_valid_reg;
    logic                 pend_valid_next;
    out_t                 pend_reg;
    out_t                 pend_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    out_t                 out_reg;
    out_t                 out_next;

    logic                 gen;
    out_t                 gen_res;
    logic [NUM_GPIOS-1:0] pol;
    logic [NUM_GPIOS-1:0] now;
    logic [NUM_GPIOS-1:0] prev;
    logic [NUM_GPIOS-1:0] hit;
    logic [NUM_GPIOS-1:0] used;
    logic [NUM_GPIOS-1:0] levels;
    logic [NUM_GPIOS-1:0] act;
    logic [NUM_GPIOS-1:0] mem;
    logic                 activation;
    logic                 match;

    assign strobe = out_valid_reg;
    assign result = out_reg;

    // per step chord match for the current gpio and slot
    always_comb
    begin
        pol        = cfg.polarity_mask[NUM_GPIOS-1:0];
        now        = job_reg.now[NUM_GPIOS-1:0];
        prev       = job_reg.prev[NUM_GPIOS-1:0];
        hit        = job_reg.hit[NUM_GPIOS-1:0];
        used       = job_reg.used[NUM_GPIOS-1:0];
        activation = ~(now[g_reg] ^ pol[g_reg]);
        levels     = activation ? now : prev;
        act        = ~(levels ^ pol) & used;
        mem        = members_reg[s_reg];
        match      = hit[g_reg] && mem[g_reg] && ((mem & ~act) == '0);
    end

    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        g_next          = g_reg;
        s_next          = s_reg;
        found_next      = found_reg;
        pstep_next      = pstep_reg;
        members_next    = members_reg;
        code_next       = code_reg;
        mtype_next      = mtype_reg;
        active_next     = active_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = 1'b0;
        out_next        = out_reg;
        pop             = 1'b0;
        gen             = 1'b0;
        gen_res         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty)
                begin
                    pop      = 1'b1;
                    job_next = rd_job;
                    case (rd_job.command)
                        CMD_EXPANDER:
                        begin
                            state_next = ST_WALK;
                            g_next     = '0;
                            s_next     = '0;
                            found_next = 1'b0;
                        end
                        CMD_POWER:
                        begin
                            state_next = ST_POWER;
                            pstep_next = '0;
                        end
                        CMD_MAP_WRITE:
                        begin
                            if ({1'b0, rd_job.entry_index} < 3'(NUM_MAPPINGS))
                            begin
                                members_next[rd_job.entry_index[SW-1:0]] =
                                    rd_job.entry_gpios[NUM_GPIOS-1:0];
                                code_next[rd_job.entry_index[SW-1:0]]    = rd_job.entry_key;
                                mtype_next[rd_job.entry_index[SW-1:0]]   = rd_job.entry_kind;
                                active_next[rd_job.entry_index[SW-1:0]]  = 1'b0;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                gen_res.key_code = code_reg[s_reg];
                gen_res.kind     = mtype_reg[s_reg];
                gen_res.slot     = 2'(s_reg);
                if (match)
                begin
                    if (activation)
                    begin
                        if (found_reg && active_reg[s_reg])
                        begin
                            active_next[s_reg] = 1'b0;
                            gen                = 1'b1;
                            gen_res.pressed    = 1'b0;
                        end
                        else if (!found_reg)
                        begin
                            active_next[s_reg] = 1'b1;
                            gen                = 1'b1;
                            gen_res.pressed    = 1'b1;
                        end
                    end
                    else if (active_reg[s_reg])
                    begin
                        active_next[s_reg] = 1'b0;
                        gen                = 1'b1;
                        gen_res.pressed    = 1'b0;
                    end
                end
                found_next = found_reg | match;
                if (s_reg == SW'(NUM_MAPPINGS - 1))
                begin
                    s_next     = '0;
                    found_next = 1'b0;
                    if (g_reg == GW'(NUM_GPIOS - 1))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        g_next = g_reg + 1'b1;
                    end
                end
                else
                begin
                    s_next = s_reg + 1'b1;
                end
            end
            ST_POWER:
            begin
                gen_res.kind    = 1'b0;
                gen_res.slot    = '0;
                gen_res.pressed = ~pstep_reg[0];
                if (pstep_reg[1])
                begin
                    gen              = job_reg.long_press;
                    gen_res.key_code = cfg.long_press_key;
                end
                else
                begin
                    gen              = job_reg.short_press;
                    gen_res.key_code = cfg.short_press_key;
                end
                if (pstep_reg == 2'd3)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    pstep_next = pstep_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_next       = pend_reg;
                    out_next.last  = 1'b1;
                end
                pend_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // hold one result back so the final one can be marked
        if (gen)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = pend_reg;
            end
            pend_next       = gen_res;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg   <= job_next;
        g_reg     <= g_next;
        s_reg     <= s_next;
        found_reg <= found_next;
        pstep_reg <= pstep_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int s = 0; s < NUM_MAPPINGS; s++)
            begin
                members_reg[s] <= '0;
                code_reg[s]    <= '0;
                mtype_reg[s]   <= 1'b0;
                active_reg[s]  <= 1'b0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            members_reg    <= members_next;
            code_reg       <= code_next;
            mtype_reg      <= mtype_next;
            active_reg     <= active_next;
        end
    end

    `GCKM_ASSERT_NEXT(a_flush_marks_last, clk, rst_n, state_reg == ST_FLUSH && pend_valid_reg, out_valid_reg && out_reg.last)
    `GCKM_ASSERT_IMPL(a_idle_nothing_held, clk, rst_n, state_reg == ST_IDLE, !pend_valid_reg)
    `GCKM_ASSERT_NEXT(a_no_early_last, clk, rst_n, state_reg == ST_WALK || state_reg == ST_POWER, !(out_valid_reg && out_reg.last))

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import gckm_pkg::*;

    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         SETTLE_CYCLES = 250;
    localparam int         CYCLE_LIMIT   = 400000;

    class chord_event_board;
        logic [63:0] pin_map;
        logic [15:0] polarity;
        logic [4:0]  gpio_count;
        logic [9:0]  short_key;
        logic [9:0]  long_key;
        logic [15:0] levels;
        bit          slot_active [NUM_MAPPINGS_DEF];
        logic [15:0] members [NUM_MAPPINGS_DEF];
        logic [9:0]  code [NUM_MAPPINGS_DEF];
        logic        shell [NUM_MAPPINGS_DEF];
        out_t        batch[$];
        out_t        expected_events[$];
        int          errors;

        function new();
            pin_map    = PIN_MAP_RST;
            polarity   = POLARITY_RST;
            gpio_count = GPIO_COUNT_RST;
            short_key  = SHORT_KEY_RST;
            long_key   = LONG_KEY_RST;
            levels     = '0;
            errors     = 0;
            for (int s = 0; s < NUM_MAPPINGS_DEF; s++)
            begin
                slot_active[s] = 1'b0;
                members[s]     = '0;
                code[s]        = '0;
                shell[s]       = 1'b0;
            end
        endfunction

        function void write_register(logic [2:0] idx, logic [63:0] value);
            case (idx)
                REG_PIN_MAP:    pin_map    = value;
                REG_POLARITY:   polarity   = value[15:0];
                REG_GPIO_COUNT: gpio_count = value[4:0];
                REG_SHORT_KEY:  short_key  = value[9:0];
                REG_LONG_KEY:   long_key   = value[9:0];
                default: ;
            endcase
        endfunction

        function int used_count();
            return (gpio_count > NUM_GPIOS_DEF) ? NUM_GPIOS_DEF : int'(gpio_count);
        endfunction

        function void emit(logic [9:0] key, logic pr, logic knd, int s);
            out_t e;
            e.key_code = key;
            e.pressed  = pr;
            e.kind     = knd;
            e.slot     = 2'(s);
            e.last     = 1'b0;
            batch.push_back(e);
        endfunction

        function void walk_slots(int g, logic [15:0] lv, logic [15:0] used, bit activation);
            logic [15:0] act;
            bit          found;
            act   = ~(lv ^ polarity) & used;
            found = 1'b0;
            for (int s = 0; s < NUM_MAPPINGS_DEF; s++)
            begin
                if (!members[s][g] || (members[s] & ~act) != '0)
                    continue;
                if (activation)
                begin
                    if (found && slot_active[s])
                    begin
                        slot_active[s] = 1'b0;
                        emit(code[s], 1'b0, shell[s], s);
                    end
                    else if (!found)
                    begin
                        slot_active[s] = 1'b1;
                        emit(code[s], 1'b1, shell[s], s);
                    end
                end
                else if (slot_active[s])
                begin
                    slot_active[s] = 1'b0;
                    emit(code[s], 1'b0, shell[s], s);
                end
                found = 1'b1;
            end
        endfunction

        function void note_command(in_t it);
            int          cnt;
            logic [15:0] used;
            logic [15:0] prev;
            logic [15:0] now;
            logic [15:0] hit;
            logic [3:0]  pin;
            batch.delete();
            case (it.command)
                CMD_EXPANDER:
                begin
                    cnt  = used_count();
                    used = 16'((32'd1 << cnt) - 32'd1);
                    prev = levels;
                    now  = '0;
                    hit  = '0;
                    for (int g = 0; g < cnt; g++)
                    begin
                        pin    = pin_map[4*g +: 4];
                        now[g] = it.level_mask[pin];
                        hit[g] = it.irq_mask[pin];
                    end
                    hit    = (hit | (now ^ prev)) & used;
                    levels = now;
                    for (int g = 0; g < cnt; g++)
                    begin
                        if (!hit[g])
                            continue;
                        if (now[g] == polarity[g])
                            walk_slots(g, now, used, 1'b1);
                        else
                            walk_slots(g, prev, used, 1'b0);
                    end
                end
                CMD_POWER:
                begin
                    if (it.short_press)
                    begin
                        emit(short_key, 1'b1, 1'b0, 0);
                        emit(short_key, 1'b0, 1'b0, 0);
                    end
                    if (it.long_press)
                    begin
                        emit(long_key, 1'b1, 1'b0, 0);
                        emit(long_key, 1'b0, 1'b0, 0);
                    end
                end
                CMD_MAP_WRITE:
                begin
                    if (int'(it.entry_index) < NUM_MAPPINGS_DEF)
                    begin
                        members[it.entry_index]     = it.entry_gpios;
                        code[it.entry_index]        = it.entry_key;
                        shell[it.entry_index]       = it.entry_kind;
                        slot_active[it.entry_index] = 1'b0;
                    end
                end
                default: ;
            endcase
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                expected_events.push_back(batch[i]);
        endfunction

        function void check_event(out_t r);
            out_t e;
            if (expected_events.size() == 0)
            begin
                $error("unexpected event key_code %0d pressed %0d", r.key_code, r.pressed);
                errors++;
                return;
            end
            e = expected_events.pop_front();
            if (r.key_code !== e.key_code)
            begin
                $error("key_code expected %0d got %0d", e.key_code, r.key_code);
                errors++;
            end
            if (r.pressed !== e.pressed)
            begin
                $error("pressed expected %0d got %0d", e.pressed, r.pressed);
                errors++;
            end
            if (r.kind !== e.kind)
            begin
                $error("kind expected %0d got %0d", e.kind, r.kind);
                errors++;
            end
            if (r.slot !== e.slot)
            begin
                $error("slot expected %0d got %0d", e.slot, r.slot);
                errors++;
            end
            if (r.last !== e.last)
            begin
                $error("last expected %0d got %0d", e.last, r.last);
                errors++;
            end
        endfunction

        function int outstanding();
            return expected_events.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    in_t         item;
    logic        strobe;
    out_t        result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    chord_event_board board;
    logic [15:0]      held;
    int               idle_pct;
    int               cycles;

    gpio_chord_key_mapper_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .strobe  (strobe),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            board.check_event(result);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic in_t base_item(logic [1:0] cmd);
        in_t it;
        it.command     = cmd;
        it.irq_mask    = 16'($urandom);
        it.level_mask  = 16'($urandom);
        it.short_press = 1'($urandom_range(1));
        it.long_press  = 1'($urandom_range(1));
        it.entry_index = 2'($urandom_range(3));
        it.entry_gpios = 16'($urandom);
        it.entry_key   = 10'($urandom);
        it.entry_kind  = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic in_t power_item(logic sp, logic lp);
        in_t it;
        it             = base_item(CMD_POWER);
        it.short_press = sp;
        it.long_press  = lp;
        return it;
    endfunction

    function automatic in_t map_item(logic [1:0] idx, logic [15:0] gpios, logic [9:0] key,
                                     logic knd);
        in_t it;
        it             = base_item(CMD_MAP_WRITE);
        it.entry_index = idx;
        it.entry_gpios = gpios;
        it.entry_key   = key;
        it.entry_kind  = knd;
        return it;
    endfunction

    function automatic in_t expander_item(logic [15:0] irq, logic [15:0] lvl);
        in_t it;
        it            = base_item(CMD_EXPANDER);
        it.irq_mask   = irq;
        it.level_mask = lvl;
        return it;
    endfunction

    // pin levels that make exactly the held gpios active, lower indices win shared pins
    function automatic logic [15:0] levels_for_held();
        logic [15:0] lvl;
        logic [3:0]  pin;
        lvl = 16'($urandom);
        for (int g = NUM_GPIOS_DEF - 1; g >= 0; g--)
        begin
            pin      = board.pin_map[4*g +: 4];
            lvl[pin] = held[g] ? board.polarity[g] : ~board.polarity[g];
        end
        return lvl;
    endfunction

    function automatic in_t random_item();
        int          pick;
        int          s;
        int          cnt;
        logic [15:0] chord;
        logic [15:0] irq;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            cnt = board.used_count();
            if (cnt == 0)
                cnt = NUM_GPIOS_DEF;
            chord = '0;
            if ($urandom_range(9) < 7)
            begin
                repeat ($urandom_range(3, 1))
                    chord[$urandom_range(cnt - 1)] = 1'b1;
            end
            else
                chord = 16'($urandom);
            return map_item(2'($urandom_range(3)), chord, 10'($urandom),
                            1'($urandom_range(1)));
        end
        if (pick < 18)
            return power_item(1'($urandom_range(1)), 1'($urandom_range(1)));
        if (pick < 21)
            return base_item(CMD_UNUSED);
        if (pick < 31)
            return expander_item(16'($urandom), 16'($urandom));
        s = $urandom_range(NUM_MAPPINGS_DEF - 1);
        case ($urandom_range(3))
            0: held = board.members[s];
            1: held = held | board.members[s];
            2: held[$urandom_range(NUM_GPIOS_DEF - 1)] = 1'b0;
            default: held = '0;
        endcase
        irq = ($urandom_range(3) == 0) ? (16'd1 << $urandom_range(15)) : 16'd0;
        return expander_item(irq, levels_for_held());
    endfunction

    task automatic drive_item(in_t it);
        int gap;
        item  <= it;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_command(it);
        if (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(40, 1);
            start <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        board.write_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(logic [63:0] pm, logic [15:0] pol, logic [4:0] cnt,
                             logic [9:0] sk, logic [9:0] lk);
        write_reg(REG_PIN_MAP, pm);
        write_reg(REG_POLARITY, {48'd0, pol});
        write_reg(REG_GPIO_COUNT, {59'd0, cnt});
        write_reg(REG_SHORT_KEY, {54'd0, sk});
        write_reg(REG_LONG_KEY, {54'd0, lk});
    endtask

    // hold off until every expected event is out and the engine has emptied
    task automatic drain();
        start <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_random(int count, int pct);
        idle_pct = pct;
        repeat (count)
            drive_item(random_item());
        drain();
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        start    <= 1'b0;
        item     <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        held     = '0;
        idle_pct = 0;
        cycles   = 0;
        board    = new();
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: identity pin map, active low
        drive_item(power_item(1'b1, 1'b0));
        drive_item(power_item(1'b1, 1'b1));
        drive_item(power_item(1'b0, 1'b1));
        drive_item(power_item(1'b0, 1'b0));
        drive_item(base_item(CMD_UNUSED));
        drive_item(map_item(2'd0, 16'h0003, 10'd30, 1'b0));
        drive_item(map_item(2'd1, 16'h0002, 10'h3FF, 1'b1));
        drive_item(map_item(2'd2, 16'h0007, 10'd0, 1'b0));
        drive_item(map_item(2'd3, 16'h0000, 10'd5, 1'b1));
        drive_item(expander_item(16'h0000, 16'h0000));
        drive_item(expander_item(16'hFFFF, 16'h0000));
        drive_item(expander_item(16'h0000, 16'hFFFF));
        drive_item(expander_item(16'h0000, 16'h0000));
        drive_item(expander_item(16'hFFFF, 16'hFFFF));
        drive_item(map_item(2'd0, 16'hFFFF, 10'h3FF, 1'b1));
        drive_item(expander_item(16'h0000, 16'h0000));
        drive_item(expander_item(16'h0001, 16'h0001));
        drive_item(expander_item(16'h0000, 16'h0000));
        drive_item(map_item(2'd1, 16'h8000, 10'd7, 1'b1));
        drive_item(expander_item(16'h0000, 16'h8000));
        drive_item(expander_item(16'h0000, 16'h0000));
        run_random(26, 0);

        configure({$urandom, $urandom}, 16'hFFFF, 5'd16, 10'd0, 10'h3FF);
        run_random(26, 82);

        configure(64'd0, 16'h0000, 5'd31, 10'h3FF, 10'd0);
        run_random(26, 7);

        configure(64'hFFFF_FFFF_FFFF_FFFF, 16'($urandom), 5'd0, 10'($urandom), 10'($urandom));
        run_random(12, 0);

        configure({$urandom, $urandom}, 16'($urandom), 5'd5, 10'($urandom), 10'($urandom));
        run_random(30, 82);

        configure(PIN_MAP_RST, 16'($urandom), 5'd1, 10'($urandom), 10'($urandom));
        run_random(26, 7);

        configure(PIN_MAP_RST, 16'($urandom), 5'd17, 10'($urandom), 10'($urandom));
        run_random(34, 0);

        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
